// ----- hw/rtl/hms_pkg.sv -----
// Shared constants and codes for the hashed multiset table.
// No dependencies; used by hashed_multiset_table.
`timescale 1ns / 1ps
`default_nettype none

package hms_pkg;

    localparam int NUM_BUCKETS   = 16;
    localparam int BUCKET_DEPTH  = 8;
    localparam int KEY_WIDTH     = 32;
    localparam int SLOT_TOTAL    = NUM_BUCKETS * BUCKET_DEPTH;

    localparam int BUCKET_W      = $clog2(NUM_BUCKETS);
    localparam int DEPTH_W       = $clog2(BUCKET_DEPTH);
    localparam int SLOT_W        = BUCKET_W + DEPTH_W;
    localparam int KEY_IDX_W     = $clog2(KEY_WIDTH);

    localparam int CFG_W         = 5;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 4;
    localparam int TOTAL_W       = 8;

    localparam logic [CFG_W-1:0] RESET_BUCKETS = CFG_W'(10);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_COUNT  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hms_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hashed_multiset_table.sv -----
// Top level of the hashed multiset table: sequencer, serial modulo unit, slot walk.
// Depends on hms_pkg and hms_ram.
`timescale 1ns / 1ps
`default_nettype none

// Bounded multiset of 32-bit keys in 16 buckets of 8 slots. A request is registered,
// then the bit-serial remainder unit takes key mod the bucket count, MSB first, then
// the slot walk: insert tests the valid bit of each slot and stops at the first free
// slot; erase and count read the key RAM, then compare, for each slot (erase stops at
// the first match); last, the result is loaded. Operation 3 skips the division and the
// slot walk. The input is not ready while a request is in progress; a finished result
// waits in the output register while the next request is taken. Bucket count writes
// are ignored while the table holds any element; 0 acts as 1 and values above 16
// act as 16. Valid bits clear at reset; no sweep.
module hashed_multiset_table (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hms_pkg::CFG_W-1:0]       cfg_data,

    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [hms_pkg::OP_W-1:0]        operation,
    input  wire logic [31:0]                     key,

    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [hms_pkg::STATUS_W-1:0]    status,
    output logic      [hms_pkg::OCC_W-1:0]       occurrences,
    output logic      [hms_pkg::TOTAL_W-1:0]     total_elements
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_CMP,
        S_DONE
    } state_t;

    state_t                              state_reg;
    hms_pkg::op_t                        op_reg;
    logic [hms_pkg::KEY_WIDTH-1:0]       key_reg;
    logic [hms_pkg::KEY_IDX_W-1:0]       bit_cnt_reg;
    logic [hms_pkg::CFG_W-1:0]           rem_reg;
    logic [hms_pkg::DEPTH_W-1:0]         slot_cnt_reg;
    logic [hms_pkg::CFG_W-1:0]           buckets_used_reg;
    logic [hms_pkg::TOTAL_W-1:0]         element_total_reg;
    logic [hms_pkg::SLOT_TOTAL-1:0]      slot_valid_reg;
    hms_pkg::status_t                    res_status_reg;
    logic [hms_pkg::OCC_W-1:0]           res_occ_reg;

    logic                                out_valid_reg;
    logic [hms_pkg::STATUS_W-1:0]        status_reg;
    logic [hms_pkg::OCC_W-1:0]           occurrences_reg;
    logic [hms_pkg::TOTAL_W-1:0]         total_elements_reg;

    logic [hms_pkg::CFG_W-1:0]           divisor;
    logic [hms_pkg::CFG_W:0]             trial;
    logic [hms_pkg::CFG_W:0]             trial_sub;
    logic [hms_pkg::CFG_W-1:0]           rem_next;
    logic [hms_pkg::SLOT_W-1:0]          slot_addr;
    logic                                last_slot;
    logic                                key_match;
    logic                                ram_we;
    logic [hms_pkg::KEY_WIDTH-1:0]       ram_rdata;

    // Effective bucket count: 0 acts as 1, large values clamp
    always_comb
    begin
        priority if (buckets_used_reg == '0)
            divisor = hms_pkg::CFG_W'(1);
        else if (buckets_used_reg > hms_pkg::CFG_W'(hms_pkg::NUM_BUCKETS))
            divisor = hms_pkg::CFG_W'(hms_pkg::NUM_BUCKETS);
        else
            divisor = buckets_used_reg;
    end

    // One restoring step of key mod divisor, MSB first
    assign trial     = {rem_reg, key_reg[bit_cnt_reg]};
    assign trial_sub = trial - {1'b0, divisor};
    assign rem_next  = (trial >= {1'b0, divisor}) ? trial_sub[hms_pkg::CFG_W-1:0]
                                                  : trial[hms_pkg::CFG_W-1:0];

    assign slot_addr = {rem_reg[hms_pkg::BUCKET_W-1:0], slot_cnt_reg};
    assign last_slot = (slot_cnt_reg == hms_pkg::DEPTH_W'(hms_pkg::BUCKET_DEPTH - 1));
    assign key_match = slot_valid_reg[slot_addr] && (ram_rdata == key_reg);
    assign ram_we    = (state_reg == S_SCAN) && (op_reg == hms_pkg::OP_INSERT)
                       && !slot_valid_reg[slot_addr];

    hms_ram #(
        .WIDTH (hms_pkg::KEY_WIDTH),
        .DEPTH (hms_pkg::SLOT_TOTAL)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (slot_addr),
        .wdata (key_reg),
        .rdata (ram_rdata)
    );

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign occurrences    = occurrences_reg;
    assign total_elements = total_elements_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            op_reg             <= hms_pkg::OP_NONE;
            key_reg            <= '0;
            bit_cnt_reg        <= '0;
            rem_reg            <= '0;
            slot_cnt_reg       <= '0;
            buckets_used_reg   <= hms_pkg::RESET_BUCKETS;
            element_total_reg  <= '0;
            slot_valid_reg     <= '0;
            res_status_reg     <= hms_pkg::ST_OK;
            res_occ_reg        <= '0;
            out_valid_reg      <= 1'b0;
            status_reg         <= '0;
            occurrences_reg    <= '0;
            total_elements_reg <= '0;
        end
        else
        begin
            // S_DONE drives the output valid itself
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && (element_total_reg == '0))
            begin
                buckets_used_reg <= cfg_data;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= hms_pkg::op_t'(operation);
                        key_reg        <= key;
                        bit_cnt_reg    <= hms_pkg::KEY_IDX_W'(hms_pkg::KEY_WIDTH - 1);
                        rem_reg        <= '0;
                        slot_cnt_reg   <= '0;
                        res_status_reg <= hms_pkg::ST_OK;
                        res_occ_reg    <= '0;
                        if (hms_pkg::op_t'(operation) == hms_pkg::OP_NONE)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    rem_reg     <= rem_next;
                    bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= S_SCAN;
                    end
                end

                // Insert resolves here from the valid bits; erase and count read the key
                S_SCAN:
                begin
                    if (op_reg == hms_pkg::OP_INSERT)
                    begin
                        if (!slot_valid_reg[slot_addr])
                        begin
                            slot_valid_reg[slot_addr] <= 1'b1;
                            element_total_reg         <= element_total_reg + 1'b1;
                            res_status_reg            <= hms_pkg::ST_OK;
                            state_reg                 <= S_DONE;
                        end
                        else if (last_slot)
                        begin
                            res_status_reg <= hms_pkg::ST_FULL;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            slot_cnt_reg <= slot_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CMP;
                    end
                end

                S_CMP:
                begin
                    if (op_reg == hms_pkg::OP_ERASE && key_match)
                    begin
                        slot_valid_reg[slot_addr] <= 1'b0;
                        if (element_total_reg != '0)
                            element_total_reg <= element_total_reg - 1'b1;
                        res_status_reg <= hms_pkg::ST_OK;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        if (op_reg == hms_pkg::OP_COUNT && key_match)
                            res_occ_reg <= res_occ_reg + 1'b1;
                        if (last_slot)
                        begin
                            if (op_reg == hms_pkg::OP_ERASE)
                                res_status_reg <= hms_pkg::ST_MISSING;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            slot_cnt_reg <= slot_cnt_reg + 1'b1;
                            state_reg    <= S_SCAN;
                        end
                    end
                end

                // Hand the result over once the output register is free
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg      <= 1'b1;
                        status_reg         <= res_status_reg;
                        occurrences_reg    <= res_occ_reg;
                        total_elements_reg <= element_total_reg;
                        state_reg          <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
